// ===== src/fireps_pkg.sv =====
`timescale 1ns / 1ps

package fireps_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int SIZE_W      = ADDR_W + 1;
    localparam int DIM_W       = 9;
    localparam int HEAT_W      = 7;
    localparam int CH_W        = 8;
    localparam int BG_W        = 32;
    localparam int PIX_W       = 24;
    localparam int IN_TDATA_W  = 40;
    localparam int CFG_IDX_W   = 1;
    localparam int PROD_W      = 2 * CH_W;

    localparam int SPREAD_MUL_W = 19;
    localparam int SPREAD_SHIFT = 20;
    localparam logic [SPREAD_MUL_W-1:0] SPREAD_MUL = 19'd350225;
    localparam logic [CH_W-1:0] SEED_MIN = 8'd128;
    localparam logic [CH_W-1:0] CH_MAX   = 8'hFF;

    typedef logic [ADDR_W-1:0]    t_addr;
    typedef logic [SIZE_W-1:0]    t_size;
    typedef logic [DIM_W-1:0]     t_dim;
    typedef logic [HEAT_W-1:0]    t_heat;
    typedef logic [CH_W-1:0]      t_chan;
    typedef logic [PROD_W-1:0]    t_prod;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_FRAME_WIDTH  = 1'b0;
    localparam t_cfg_idx CFG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        t_dim  width;
        t_size size;
        t_size lim;
    } t_geom;

    typedef struct packed {
        t_heat           heat;
        logic [BG_W-1:0] bg;
        logic            last;
    } t_heat_item;

    function automatic t_dim eff_width(input t_dim d);
        t_dim r;
        r = d;
        if (int'(d) < 1) r = DIM_W'(1);
        if (int'(d) > MAX_WIDTH) r = DIM_W'(MAX_WIDTH);
        return r;
    endfunction

    function automatic t_dim eff_height(input t_dim d);
        t_dim r;
        r = d;
        if (int'(d) < 2) r = DIM_W'(2);
        if (int'(d) > MAX_HEIGHT) r = DIM_W'(MAX_HEIGHT);
        return r;
    endfunction

    function automatic t_chan div255(input logic [PROD_W:0] x);
        logic [PROD_W:0] y;
        y = x + (x >> CH_W) + (PROD_W+1)'(1);
        return y[PROD_W-1:CH_W];
    endfunction

endpackage

// ===== src/fireps_heat_ram.sv =====
`timescale 1ns / 1ps

module fireps_heat_ram (
    input  logic               i_clk,
    input  logic               i_we,
    input  fireps_pkg::t_addr  i_waddr,
    input  fireps_pkg::t_heat  i_wdata,
    input  logic               i_re,
    input  fireps_pkg::t_addr  i_raddr_a,
    input  fireps_pkg::t_addr  i_raddr_b,
    output fireps_pkg::t_heat  o_rdata_a,
    output fireps_pkg::t_heat  o_rdata_b
);
    import fireps_pkg::*;

    t_heat r_mem [STORE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

// ===== src/fireps_heat_stage.sv =====
`timescale 1ns / 1ps

module fireps_heat_stage (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [31:0]            i_background,
    input  fireps_pkg::t_heat      i_random,
    input  fireps_pkg::t_geom      i_geom,
    output logic                   o_valid,
    output fireps_pkg::t_heat_item o_item,
    input  logic                   i_ready
);
    import fireps_pkg::*;

    typedef struct packed {
        t_addr           idx;
        logic [BG_W-1:0] bg;
        t_heat           rnd;
        logic            first;
        logic            spread;
        logic            last;
    } t_s1;

    logic       r_clr_busy;
    t_addr      r_clr_addr;
    t_addr      r_pidx;
    logic       r_v1;
    t_s1        r_s1;
    t_heat      r_left;
    t_heat      r_right;
    logic       r_byp;
    t_heat      r_byp_heat;
    logic       r_v2;
    t_heat_item r_s2;

    t_addr      idx;
    t_addr      n_pidx;
    t_addr      raddr_a;
    t_addr      raddr_b;
    t_heat      rd_a;
    t_heat      rd_b;
    t_heat      rd_right;
    logic       accept;
    logic       s1_move;
    logic       s2_ready;
    logic       last;
    logic       seed;
    logic [HEAT_W+1:0] sum;
    logic [HEAT_W+2+SPREAD_MUL_W-1:0] spread_prod;
    t_heat      cur_old;
    t_heat      heat;
    logic       we;
    t_addr      waddr;
    t_heat      wdata;
    t_s1        n_s1;

    assign s2_ready = !r_v2 || i_ready;
    assign s1_move  = r_v1 && s2_ready;
    assign o_ready  = (!r_v1 || s2_ready) && !r_clr_busy;
    assign accept   = i_valid && o_ready;

    always_comb begin
        idx     = ({1'b0, r_pidx} >= i_geom.size) ? '0 : r_pidx;
        last    = ({1'b0, idx} == (i_geom.size - SIZE_W'(1)));
        n_pidx  = last ? '0 : idx + ADDR_W'(1);
        raddr_a = idx + ADDR_W'(1);
        raddr_b = (idx == '0) ? '0 : idx + ADDR_W'(i_geom.width);
        n_s1.idx    = idx;
        n_s1.bg     = i_background;
        n_s1.rnd    = i_random;
        n_s1.first  = (idx == '0);
        n_s1.spread = (idx != '0) && ({1'b0, idx} < i_geom.lim);
        n_s1.last   = last;
    end

    fireps_heat_ram u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_re      (accept),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    always_comb begin
        rd_right = r_byp ? r_byp_heat : rd_a;
        seed = (r_s1.bg[7:0] == r_s1.bg[15:8]) && (r_s1.bg[31:24] != '0)
            && (r_s1.bg[7:0] > SEED_MIN);
        sum = (HEAT_W+2)'(r_left) + (HEAT_W+2)'(rd_right) + (HEAT_W+2)'(rd_b);
        spread_prod = (HEAT_W+2+SPREAD_MUL_W)'(sum) * (HEAT_W+2+SPREAD_MUL_W)'(SPREAD_MUL);
        cur_old = r_s1.first ? rd_b : r_right;
        if (seed) begin
            heat = r_s1.rnd;
        end else if (r_s1.spread) begin
            heat = spread_prod[SPREAD_SHIFT +: HEAT_W];
        end else begin
            heat = cur_old;
        end
        we    = r_clr_busy || s1_move;
        waddr = r_clr_busy ? r_clr_addr : r_s1.idx;
        wdata = r_clr_busy ? '0 : heat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_pidx     <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
                if (&r_clr_addr) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (accept) begin
                r_pidx <= n_pidx;
            end
            if (accept) begin
                r_v1 <= 1'b1;
            end else if (s1_move) begin
                r_v1 <= 1'b0;
            end
            if (s1_move) begin
                r_v2 <= 1'b1;
            end else if (i_ready) begin
                r_v2 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1       <= n_s1;
            r_byp      <= s1_move && (r_s1.idx == raddr_a);
            r_byp_heat <= heat;
        end
        if (s1_move) begin
            r_left       <= heat;
            r_right      <= rd_right;
            r_s2.heat    <= heat;
            r_s2.bg      <= r_s1.bg;
            r_s2.last    <= r_s1.last;
        end
    end

    assign o_valid = r_v2;
    assign o_item  = r_s2;

endmodule

// ===== src/fireps_blend.sv =====
`timescale 1ns / 1ps

module fireps_blend (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  fireps_pkg::t_heat_item i_item,
    output logic                   o_valid,
    output logic [23:0]            o_pixel,
    output logic                   o_last,
    input  logic                   i_ready
);
    import fireps_pkg::*;

    typedef struct packed {
        t_prod red;
        t_prod green_top;
        t_prod green_back;
        t_prod blue_top;
        t_prod blue_back;
        logic  last;
    } t_prods;

    logic        r_v3;
    t_prods      r_p;
    logic        r_vo;
    logic [PIX_W-1:0] r_pix;
    logic        r_last;

    logic        s3_ready;
    logic        s3_move;
    logic [CH_W:0] alpha3;
    t_chan       alpha;
    t_chan       inv_alpha;
    t_chan       ramp_g;
    t_prods      n_p;
    t_chan       red;
    t_chan       green;
    t_chan       blue;

    assign s3_ready = !r_vo || i_ready;
    assign s3_move  = r_v3 && s3_ready;
    assign o_ready  = !r_v3 || s3_ready;

    always_comb begin
        alpha3    = (CH_W+1)'(i_item.heat) + (CH_W+1)'({i_item.heat, 1'b0});
        alpha     = alpha3[CH_W-1:0];
        inv_alpha = CH_MAX - alpha;
        ramp_g    = (i_item.heat == '0) ? CH_MAX : ({1'b0, i_item.heat} << 1) - CH_W'(1);
        n_p.red        = t_prod'(i_item.bg[23:16]) * t_prod'(inv_alpha);
        n_p.green_top  = t_prod'(ramp_g) * t_prod'(alpha);
        n_p.green_back = t_prod'(i_item.bg[15:8]) * t_prod'(inv_alpha);
        n_p.blue_top   = (t_prod'(alpha) << CH_W) - t_prod'(alpha);
        n_p.blue_back  = t_prod'(i_item.bg[7:0]) * t_prod'(inv_alpha);
        n_p.last       = i_item.last;
    end

    always_comb begin
        red   = div255({1'b0, r_p.red});
        green = div255({1'b0, r_p.green_top} + {1'b0, r_p.green_back});
        blue  = div255({1'b0, r_p.blue_top} + {1'b0, r_p.blue_back});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_v3 <= 1'b1;
            end else if (s3_move) begin
                r_v3 <= 1'b0;
            end
            if (s3_move) begin
                r_vo <= 1'b1;
            end else if (i_ready) begin
                r_vo <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_p <= n_p;
        end
        if (s3_move) begin
            r_pix  <= {red, green, blue};
            r_last <= r_p.last;
        end
    end

    assign o_valid = r_vo;
    assign o_pixel = r_pix;
    assign o_last  = r_last;

endmodule

// ===== src/fire_effect_pixel_stream_unit.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  background pixel, random heat
// m_axis    out        m_axis_tvalid / m_axis_tready  blended RGB pixel, frame end on tlast
// cfg       in         i_cfg_valid / o_cfg_ready      register index, write data
//
// One pixel per cycle sustained while m_axis_tready is high; a pixel is registered in r_s1, r_s2, r_p, then r_pix.
// The heat update loop closes through the held left-neighbour register and a bypass register, so the
// frame store read and write ports each serve one pixel per cycle.
// After reset the frame store is cleared, one entry a cycle, with
// s_axis_tready low until it is done. Configuration writes are taken throughout.
// A stalled output holds the whole pipeline once every stage is full.

module fire_effect_pixel_stream_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [39:0]                 s_axis_tdata,   // [31:0] background_pixel, [38:32] random_value
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [23:0]                 m_axis_tdata,   // [23:0] output_pixel
    output logic                        m_axis_tlast,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  fireps_pkg::t_cfg_idx        i_cfg_index,
    input  fireps_pkg::t_dim            i_cfg_data
);
    import fireps_pkg::*;

    t_dim       r_width;
    t_dim       r_height;
    t_size      r_size;
    t_size      r_lim;

    t_dim       n_width;
    t_dim       n_height;
    logic [2*DIM_W-1:0] n_area;
    t_size      n_size;
    t_geom      geom;
    logic       heat_valid;
    logic       heat_ready;
    t_heat_item heat_item;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        case (i_cfg_index)
            CFG_FRAME_WIDTH:  n_width  = eff_width(i_cfg_data);
            CFG_FRAME_HEIGHT: n_height = eff_height(i_cfg_data);
            default: ;
        endcase
        n_area = (2*DIM_W)'(n_width) * (2*DIM_W)'(n_height);
        n_size = n_area[SIZE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(MAX_WIDTH);
            r_height <= DIM_W'(MAX_HEIGHT);
            r_size   <= SIZE_W'(STORE_DEPTH);
            r_lim    <= SIZE_W'(STORE_DEPTH - MAX_WIDTH);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_width  <= n_width;
            r_height <= n_height;
            r_size   <= n_size;
            r_lim    <= n_size - SIZE_W'(n_width);
        end
    end

    assign geom.width = r_width;
    assign geom.size  = r_size;
    assign geom.lim   = r_lim;

    fireps_heat_stage u_heat (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_background (s_axis_tdata[BG_W-1:0]),
        .i_random     (s_axis_tdata[BG_W +: HEAT_W]),
        .i_geom       (geom),
        .o_valid      (heat_valid),
        .o_item       (heat_item),
        .i_ready      (heat_ready)
    );

    fireps_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (heat_valid),
        .o_ready (heat_ready),
        .i_item  (heat_item),
        .o_valid (m_axis_tvalid),
        .o_pixel (m_axis_tdata),
        .o_last  (m_axis_tlast),
        .i_ready (m_axis_tready)
    );

endmodule

// ===== src/fireps_checker.sv =====
`timescale 1ns / 1ps

module fireps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output transfer changed while stalled");

    a_clear_blocks_input: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input taken while frame store clears");

    a_reset_empties_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid straight after reset");

endmodule

bind fire_effect_pixel_stream_unit fireps_checker u_fireps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
